// File: hw/rtl/gaussian_blur_3x3_rgb_unit_assert.svh
// Assertion macros shared by the blur unit. Each macro expects signals
// named clk and rst in the scope where it is used.
`ifndef GAUSSIAN_BLUR_3X3_RGB_UNIT_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_RGB_UNIT_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define GB3_ASSERT_SAME(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("gb3 assertion failed");

// The condition must hold in the cycle after the trigger.
`define GB3_ASSERT_NEXT(name, trig, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("gb3 assertion failed");

`endif

// File: hw/rtl/gb3_pkg.sv
package gb3_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int CHANNELS       = 3;
  localparam int CH_W           = 8;

  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_INDEX_W    = 1;

  localparam int RESET_WIDTH    = 1024;
  localparam int RESET_HEIGHT   = 1024;

  // Kernel sum reaches 16 * 255 = 4080; with rounding it still fits 12 bits.
  localparam int SUM_W          = 12;
  localparam int ROUND_ADD      = 8;
  localparam int NORM_SHIFT     = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [CHANNELS-1:0] pix_t;

  typedef struct packed {
    pix_t above;
    pix_t mid;
  } line_t;

  typedef struct packed {
    logic col_first;
    logic col_last;
    logic row_first;
    logic row_last;
  } edge_t;

endpackage

// File: hw/rtl/gb3_if.sv
interface gb3_pixel_if import gb3_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t pixel_red;
  chan_t pixel_green;
  chan_t pixel_blue;
  logic  drain;

  modport source (output valid, output pixel_red, output pixel_green,
                  output pixel_blue, output drain, input ready);
  modport sink (input valid, input pixel_red, input pixel_green,
                input pixel_blue, input drain, output ready);
endinterface

interface gb3_blur_if import gb3_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t blur_red;
  chan_t blur_green;
  chan_t blur_blue;
  logic  frame_end;

  modport source (output valid, output blur_red, output blur_green,
                  output blur_blue, output frame_end, input ready);
  modport sink (input valid, input blur_red, input blur_green,
                input blur_blue, input frame_end, output ready);
endinterface

// File: hw/rtl/gb3_line_buf.sv
module gb3_line_buf import gb3_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_t         wr_data,
  output line_t         rd_data
);

  line_t mem [DEPTH];
  line_t rd_q;
  line_t byp_q;
  logic  byp;

  // A write to the same entry in the read cycle lands too late for the
  // array read, so the written word is carried along instead.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      byp   <= wr_en && (wr_addr == rd_addr);
      byp_q <= wr_data;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = byp ? byp_q : rd_q;

endmodule

// File: hw/rtl/gb3_lane.sv
module gb3_lane import gb3_pkg::*; (
  input  chan_t [2:0][2:0] win,
  input  edge_t            edges,
  output chan_t            blur
);

  always_comb begin
    chan_t [2:0][2:0] t;
    logic [SUM_W-1:0] sum;
    t = win;
    // Replicate the nearest edge pixel over taps that fall outside the image.
    if (edges.col_first) begin
      for (int i = 0; i < 3; i++) t[i][0] = t[i][1];
    end
    if (edges.col_last) begin
      for (int i = 0; i < 3; i++) t[i][2] = t[i][1];
    end
    if (edges.row_first) begin
      t[0] = t[1];
    end
    if (edges.row_last) begin
      t[2] = t[1];
    end
    sum = SUM_W'(t[0][0]) + (SUM_W'(t[0][1]) << 1) + SUM_W'(t[0][2])
        + (SUM_W'(t[1][0]) << 1) + (SUM_W'(t[1][1]) << 2) + (SUM_W'(t[1][2]) << 1)
        + SUM_W'(t[2][0]) + (SUM_W'(t[2][1]) << 1) + SUM_W'(t[2][2])
        + SUM_W'(ROUND_ADD);
    blur = sum[NORM_SHIFT +: CH_W];
  end

endmodule

// File: hw/rtl/gaussian_blur_3x3_rgb_unit.sv
// Channel  Role    Payload                                          Handshake
// pixel    sink    pixel_red, pixel_green, pixel_blue, drain        valid/ready
// blur     source  blur_red, blur_green, blur_blue, frame_end       valid/ready
// cfg      write   cfg_index selects image_width or image_height    cfg_we
//
// One request is accepted per clock while no stage stalls; the request that
// completes a window sends its result through the line-buffer read, window
// shift and lanes. The line buffer reads one column and writes back the previous
// one each clock the pipeline moves, so the window keeps the one-per-clock rate.
// Reset is synchronous on rst and restores a 1024 x 1024 frame.
// Each stage holds its item while the one behind it is full, so a stalled
// result still lets in two more requests that produce pixels, and any number
// of requests that produce none.
`include "gaussian_blur_3x3_rgb_unit_assert.svh"

module gaussian_blur_3x3_rgb_unit import gb3_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  gb3_pixel_if.sink              pixel,
  gb3_blur_if.source             blur
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  // The row counter runs up to one past the image height while the last row drains.
  localparam int YW = $clog2(MAX_HEIGHT + 2);

  // Register values of zero act as one, values over the limit as the limit.
  function automatic logic [WW-1:0] clamp_width(input logic [IMAGE_WIDTH_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) return WW'(1);
    else if (v32 > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    else return WW'(v32);
  endfunction

  function automatic logic [HW-1:0] clamp_height(input logic [IMAGE_HEIGHT_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) return HW'(1);
    else if (v32 > 32'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    else return HW'(v32);
  endfunction

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [XW-1:0] col;
  logic [YW-1:0] row;

  // Handshake and stage moves. A stage takes a new item when it is empty or
  // its current item moves on in the same cycle.
  logic out_valid;
  logic out_free;
  logic s1_valid;
  logic s2_valid;
  logic s2_free;
  logic s1_adv;
  logic s1_move;
  logic take;

  assign out_free = !out_valid || blur.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_move  = s1_valid && s2_free;
  assign s1_adv   = !s1_valid || s2_free;
  assign pixel.ready = s1_adv;
  assign take = pixel.valid && s1_adv;

  // Decode of the request against the frame position. Once every row is in,
  // requests only flush the pipeline and carry a black pixel.
  logic  flush;
  logic  enter;
  logic  col_zero;
  logic  is_last;
  logic  emit;
  pix_t  px;
  edge_t edges;

  always_comb begin
    flush    = 32'(row) >= 32'(height_eff);
    enter    = take && (flush || !pixel.drain);
    col_zero = (col == '0);
    px[0] = flush ? '0 : pixel.pixel_red;
    px[1] = flush ? '0 : pixel.pixel_green;
    px[2] = flush ? '0 : pixel.pixel_blue;
    // A request at column x > 0 finishes pixel (row-1, x-1); at column 0 it
    // finishes the last pixel of the row two above.
    emit = (32'(row) >= 32'd2) || ((32'(row) >= 32'd1) && !col_zero);
    edges.col_first = (32'(col) == 32'd1) || (col_zero && (32'(width_eff) == 32'd1));
    edges.col_last  = col_zero;
    edges.row_first = col_zero ? (32'(row) == 32'd2) : (32'(row) == 32'd1);
    edges.row_last  = col_zero ? (32'(row) == 32'(height_eff) + 32'd1)
                               : (32'(row) == 32'(height_eff));
    is_last = col_zero && (32'(row) == 32'(height_eff) + 32'd1);
  end

  // Configuration and frame position. Any register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= clamp_width(IMAGE_WIDTH_W'(RESET_WIDTH));
      height_eff <= clamp_height(IMAGE_HEIGHT_W'(RESET_HEIGHT));
      col        <= '0;
      row        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_eff  <= clamp_width(cfg_data[IMAGE_WIDTH_W-1:0]);
        REG_IMAGE_HEIGHT: height_eff <= clamp_height(cfg_data[IMAGE_HEIGHT_W-1:0]);
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (enter) begin
      if (is_last) begin
        col <= '0;
        row <= '0;
      end else if (32'(col) + 32'd1 >= 32'(width_eff)) begin
        col <= '0;
        row <= YW'(32'(row) + 32'd1);
      end else begin
        col <= XW'(32'(col) + 32'd1);
      end
    end
  end

  // Stage one: the line buffer word for this column arrives from memory.
  logic [XW-1:0] s1_col;
  pix_t          s1_px;
  logic          s1_emit;
  edge_t         s1_edges;
  logic          s1_last;
  line_t         line_rd;
  line_t         line_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_col   <= col;
      s1_px    <= px;
      s1_emit  <= emit;
      s1_edges <= edges;
      s1_last  <= is_last;
    end
  end

  // The middle row moves up to the row above and the new pixel becomes the
  // middle row for this column.
  assign line_wr.above = line_rd.mid;
  assign line_wr.mid   = s1_px;

  gb3_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  // Stage two: the 3x3 window shifts one column and the lanes read it.
  pix_t [2:0][2:0] win;
  edge_t           s2_edges;
  logic            s2_last;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= line_rd.above;
      win[1][2] <= line_rd.mid;
      win[2][2] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_edges <= s1_edges;
      s2_last  <= s1_last;
    end
  end

  // One lane per color channel applies the edge rule and the kernel.
  pix_t lane_blur;

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    chan_t [2:0][2:0] lane_win;
    for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
        assign lane_win[i][j] = win[i][j][ch];
      end
    end
    gb3_lane u_lane (
      .win   (lane_win),
      .edges (s2_edges),
      .blur  (lane_blur[ch])
    );
  end

  // Merge stage: the lane results form one output pixel in the output register.
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  logic  out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_red   <= lane_blur[0];
      out_green <= lane_blur[1];
      out_blue  <= lane_blur[2];
      out_end   <= s2_last;
    end
  end

  assign blur.valid      = out_valid;
  assign blur.blur_red   = out_red;
  assign blur.blur_green = out_green;
  assign blur.blur_blue  = out_blue;
  assign blur.frame_end  = out_end;

  `GB3_ASSERT_SAME(a_col_in_row, 1'b1, 32'(col) < 32'(width_eff))
  `GB3_ASSERT_SAME(a_row_bound, 1'b1, 32'(row) <= 32'(height_eff) + 32'd1)
  `GB3_ASSERT_NEXT(a_frame_restart, enter && is_last, (col == '0) && (row == '0))

endmodule
